@@ rtl/cht_pkg.sv @@
// Shared types, constants and microprogram ROM for the chained hash table unit.
// No dependencies; imported by the unit, the checker and the testbench.
package cht_pkg;

    localparam int KEY_W      = 31;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int PROBE_W    = 9;
    localparam int MOD_W      = 9;
    localparam int DIV_CNT_W  = $clog2(KEY_W);

    localparam int DEF_BUCKETS    = 256;
    localparam int DEF_POOL_NODES = 256;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(2);
    localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } cht_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    found_key;
        logic [PROBE_W-1:0]  probe_count;
    } cht_out_t;

    // microprogram addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] U_INIT     = 4'd0;
    localparam logic [UPC_W-1:0] U_FETCH    = 4'd1;
    localparam logic [UPC_W-1:0] U_TST_CLR  = 4'd2;
    localparam logic [UPC_W-1:0] U_TST_NOP  = 4'd3;
    localparam logic [UPC_W-1:0] U_TST_FULL = 4'd4;
    localparam logic [UPC_W-1:0] U_DIV      = 4'd5;
    localparam logic [UPC_W-1:0] U_BKT_RD   = 4'd6;
    localparam logic [UPC_W-1:0] U_HEAD_RD  = 4'd7;
    localparam logic [UPC_W-1:0] U_CHECK    = 4'd8;
    localparam logic [UPC_W-1:0] U_TST_HEAD = 4'd9;
    localparam logic [UPC_W-1:0] U_PROBE    = 4'd10;
    localparam logic [UPC_W-1:0] U_LINK_RD  = 4'd11;
    localparam logic [UPC_W-1:0] U_RESULT   = 4'd12;
    localparam logic [UPC_W-1:0] U_CLEAR    = 4'd13;
    localparam logic [UPC_W-1:0] U_FULL     = 4'd14;
    localparam logic [UPC_W-1:0] U_INSERT   = 4'd15;

    // jump conditions
    localparam int COND_W = 4;
    localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
    localparam logic [COND_W-1:0] C_SWEEP_DONE = 4'd2;
    localparam logic [COND_W-1:0] C_ACCEPT     = 4'd3;
    localparam logic [COND_W-1:0] C_OP_CLEAR   = 4'd4;
    localparam logic [COND_W-1:0] C_OP_NOP     = 4'd5;
    localparam logic [COND_W-1:0] C_POOL_FULL  = 4'd6;
    localparam logic [COND_W-1:0] C_DIV_LAST   = 4'd7;
    localparam logic [COND_W-1:0] C_OP_INSERT  = 4'd8;
    localparam logic [COND_W-1:0] C_NO_HEAD    = 4'd9;
    localparam logic [COND_W-1:0] C_MATCH      = 4'd10;
    localparam logic [COND_W-1:0] C_HAS_NEXT   = 4'd11;
    localparam logic [COND_W-1:0] C_OUT_FREE   = 4'd12;

    typedef struct packed {
        logic sweep;    // write an empty head during the reset sweep
        logic take;     // input ready, latch a transaction
        logic div;      // one restoring-division step
        logic bkt_rd;   // read the bucket head
        logic head_rd;  // read the head node
        logic check;    // latch whether the bucket holds a live chain
        logic probe;    // compare one node
        logic link_rd;  // read the next node of the chain
        logic out_load; // move the result into the output register
        logic clear;    // free the pool
        logic full;     // insert refused
        logic insert;   // write node and new bucket head
    } cht_act_t;

    typedef struct packed {
        cht_act_t          act;
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  target;
        logic              hold;   // stay on this step while cond is false
    } cht_uword_t;

    // next = cond ? target : (hold ? upc : upc + 1)
    function automatic cht_uword_t cht_urom(input logic [UPC_W-1:0] upc);
        cht_uword_t w;
        w = '0;
        case (upc)
            U_INIT: begin
                w.act.sweep = 1'b1; w.cond = C_SWEEP_DONE; w.target = U_FETCH; w.hold = 1'b1;
            end
            U_FETCH: begin
                w.act.take = 1'b1; w.cond = C_ACCEPT; w.target = U_TST_CLR; w.hold = 1'b1;
            end
            U_TST_CLR: begin
                w.cond = C_OP_CLEAR; w.target = U_CLEAR;
            end
            U_TST_NOP: begin
                w.cond = C_OP_NOP; w.target = U_RESULT;
            end
            U_TST_FULL: begin
                w.cond = C_POOL_FULL; w.target = U_FULL;
            end
            U_DIV: begin
                w.act.div = 1'b1; w.cond = C_DIV_LAST; w.target = U_BKT_RD; w.hold = 1'b1;
            end
            U_BKT_RD: begin
                w.act.bkt_rd = 1'b1;
            end
            U_HEAD_RD: begin
                w.act.head_rd = 1'b1;
            end
            U_CHECK: begin
                w.act.check = 1'b1; w.cond = C_OP_INSERT; w.target = U_INSERT;
            end
            U_TST_HEAD: begin
                w.cond = C_NO_HEAD; w.target = U_RESULT;
            end
            U_PROBE: begin
                w.act.probe = 1'b1; w.cond = C_MATCH; w.target = U_RESULT;
            end
            U_LINK_RD: begin
                w.act.link_rd = 1'b1; w.cond = C_HAS_NEXT; w.target = U_PROBE;
            end
            U_RESULT: begin
                w.act.out_load = 1'b1; w.cond = C_OUT_FREE; w.target = U_FETCH; w.hold = 1'b1;
            end
            U_CLEAR: begin
                w.act.clear = 1'b1; w.cond = C_ALWAYS; w.target = U_RESULT;
            end
            U_FULL: begin
                w.act.full = 1'b1; w.cond = C_ALWAYS; w.target = U_RESULT;
            end
            U_INSERT: begin
                w.act.insert = 1'b1; w.cond = C_ALWAYS; w.target = U_RESULT;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = U_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/cht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the bucket head table and the node pool.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/chained_hash_table_unit.sv @@
// Chained hash table unit: microcoded sequencer, division-method hash, node pool.
// Depends on cht_pkg and cht_ram.
//
// Usage
//   Input channel (s_valid/s_ready/s_data): one transaction carries an op and a
//   key. Insert pushes the key at the head of bucket (key mod modulus), search
//   walks that bucket's chain, clear empties all buckets and frees the pool.
//   Result channel (m_valid/m_ready/m_data): exactly one result per input
//   transaction, in order: status, matched key and number of nodes probed.
//   cfg_wr_en/cfg_wr_data write the hash modulus (0/1 act as 2, values above
//   BUCKETS act as BUCKETS); write it only while the unit is idle.
// Timing
//   One transaction at a time. The hash is a restoring division, one key bit
//   per cycle. Insert runs the division and then writes the node; a refused
//   insert, clear and the unused op skip the division. Search runs the division
//   and then one node RAM read and one compare per chain node probed, with no
//   read of a further node on a hit. The next transaction is accepted the cycle
//   after the load, even while the receiver stalls; a stalled result blocks
//   only the load of the following one.
// Reset
//   aresetn (synchronous, active low) empties the table and restarts the
//   microprogram with a sweep that writes every bucket head once, with s_ready
//   low. Config writes are taken meanwhile.
module chained_hash_table_unit
    import cht_pkg::*;
#(
    parameter int BUCKETS    = DEF_BUCKETS,
    parameter int POOL_NODES = DEF_POOL_NODES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cht_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cht_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [MOD_W-1:0] cfg_wr_data
);

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int CNT_W   = $clog2(POOL_NODES + 1);
    // node word: key | has_next | link | owning bucket
    localparam int NODE_DW = KEY_W + 1 + NODE_W + BKT_W;
    localparam logic [MOD_W-1:0] MOD_CAP = MOD_W'((BUCKETS < 511) ? BUCKETS : 511);

    // ---------------- registers ----------------
    logic [UPC_W-1:0]     upc_reg, upc_next;
    logic [BKT_W-1:0]     sweep_reg, sweep_next;
    logic [MOD_W-1:0]     mod_reg, mod_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [KEY_W-1:0]     dvd_reg, dvd_next;     // dividend, shifted out MSB first
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [MOD_W-1:0]     rem_reg, rem_next;
    logic                 live_reg, live_next;   // bucket holds a chain of this pool epoch
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [KEY_W-1:0]     found_reg, found_next;
    logic [PROBE_W-1:0]   probes_reg, probes_next;
    logic                 m_valid_reg, m_valid_next;
    cht_out_t             m_data_reg, m_data_next;

    // ---------------- microcode ----------------
    cht_uword_t uw;
    logic       cond_hit;

    // ---------------- datapath signals ----------------
    logic [MOD_W-1:0]   mod_eff;
    logic [MOD_W:0]     rem_shift;
    logic [BKT_W-1:0]   bkt_idx;
    logic               out_free;
    logic               accept;

    logic               bkt_we;
    logic [BKT_W-1:0]   bkt_waddr;
    logic [NODE_W-1:0]  bkt_wdata;
    logic [NODE_W-1:0]  head_idx;       // bucket RAM read data

    logic               node_re;
    logic [NODE_W-1:0]  node_raddr;
    logic [NODE_DW-1:0] node_wdata;
    logic [NODE_DW-1:0] node_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic               rd_next;
    logic [NODE_W-1:0]  rd_link;
    logic [BKT_W-1:0]   rd_bkt;
    logic               head_live;
    logic               key_match;

    assign uw = cht_urom(upc_reg);

    assign s_ready  = uw.act.take;
    assign accept   = s_valid && uw.act.take;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // clamp the modulus into 2..BUCKETS
    always_comb begin
        if (mod_reg < MOD_MIN) begin
            mod_eff = MOD_MIN;
        end else if (mod_reg > MOD_CAP) begin
            mod_eff = MOD_CAP;
        end else begin
            mod_eff = mod_reg;
        end
    end

    assign rem_shift = {rem_reg, dvd_reg[KEY_W-1]};
    assign bkt_idx   = BKT_W'(rem_reg);

    // node word fields
    assign rd_key  = node_rdata[NODE_DW-1 -: KEY_W];
    assign rd_next = node_rdata[NODE_W + BKT_W];
    assign rd_link = node_rdata[BKT_W +: NODE_W];
    assign rd_bkt  = node_rdata[0 +: BKT_W];

    // A stale head is recognized because the node it names is either beyond
    // the fill count or was reissued to another bucket since the last clear.
    assign head_live = (CNT_W'(head_idx) < used_reg) && (rd_bkt == bkt_idx);
    assign key_match = (rd_key == key_reg);

    // ---------------- bucket head RAM ----------------
    assign bkt_we    = uw.act.sweep || uw.act.insert;
    assign bkt_waddr = uw.act.sweep ? sweep_reg : bkt_idx;
    assign bkt_wdata = uw.act.sweep ? '0 : NODE_W'(used_reg);

    cht_ram #(
        .WIDTH (NODE_W),
        .DEPTH (BUCKETS)
    ) u_bkt_ram (
        .aclk  (aclk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .re    (uw.act.bkt_rd),
        .raddr (bkt_idx),
        .rdata (head_idx)
    );

    // ---------------- node pool RAM ----------------
    assign node_re    = uw.act.head_rd || uw.act.link_rd;
    assign node_raddr = uw.act.head_rd ? head_idx : rd_link;
    assign node_wdata = {key_reg, live_reg, head_idx, bkt_idx};

    cht_ram #(
        .WIDTH (NODE_DW),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (uw.act.insert),
        .waddr (NODE_W'(used_reg)),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // ---------------- branch condition ----------------
    always_comb begin
        case (uw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_SWEEP_DONE: cond_hit = (sweep_reg == BKT_W'(BUCKETS - 1));
            C_ACCEPT:     cond_hit = s_valid;
            C_OP_CLEAR:   cond_hit = (op_reg == OP_CLEAR);
            C_OP_NOP:     cond_hit = (op_reg == OP_NOP);
            C_POOL_FULL:  cond_hit = (op_reg == OP_INSERT) &&
                                     (used_reg == CNT_W'(POOL_NODES));
            C_DIV_LAST:   cond_hit = (div_cnt_reg == DIV_CNT_W'(KEY_W - 1));
            C_OP_INSERT:  cond_hit = (op_reg == OP_INSERT);
            C_NO_HEAD:    cond_hit = !live_reg;
            C_MATCH:      cond_hit = key_match;
            C_HAS_NEXT:   cond_hit = rd_next;
            C_OUT_FREE:   cond_hit = out_free;
            default:      cond_hit = 1'b0;
        endcase
    end

    // ---------------- next state ----------------
    always_comb begin
        if (cond_hit) begin
            upc_next = uw.target;
        end else if (uw.hold) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + UPC_W'(1);
        end

        sweep_next   = uw.act.sweep ? sweep_reg + BKT_W'(1) : sweep_reg;
        mod_next     = cfg_wr_en ? cfg_wr_data : mod_reg;
        used_next    = used_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        dvd_next     = dvd_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        live_next    = live_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        probes_next  = probes_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (accept) begin
            op_next      = s_data.op;
            key_next     = s_data.key;
            dvd_next     = s_data.key;
            div_cnt_next = '0;
            rem_next     = '0;
            status_next  = (s_data.op == OP_SEARCH) ? ST_MISS : ST_OK;
            found_next   = '0;
            probes_next  = '0;
        end

        if (uw.act.div) begin
            dvd_next     = dvd_reg << 1;
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            if (rem_shift >= {1'b0, mod_eff}) begin
                rem_next = MOD_W'(rem_shift - {1'b0, mod_eff});
            end else begin
                rem_next = MOD_W'(rem_shift);
            end
        end

        if (uw.act.check) begin
            live_next = head_live;
        end

        if (uw.act.probe) begin
            probes_next = probes_reg + PROBE_W'(1);
            if (key_match) begin
                status_next = ST_OK;
                found_next  = key_reg;
            end
        end

        if (uw.act.insert) begin
            used_next = used_reg + CNT_W'(1);
        end
        if (uw.act.clear) begin
            used_next = '0;
        end
        if (uw.act.full) begin
            status_next = ST_FULL;
        end

        // output register: a waiting result is dropped on take, refilled on load
        if (uw.act.out_load && out_free) begin
            m_valid_next            = 1'b1;
            m_data_next.status      = status_reg;
            m_data_next.found_key   = found_reg;
            m_data_next.probe_count = probes_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= U_INIT;
            sweep_reg   <= '0;
            mod_reg     <= MOD_RESET;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            sweep_reg   <= sweep_next;
            mod_reg     <= mod_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        dvd_reg     <= dvd_next;
        div_cnt_reg <= div_cnt_next;
        rem_reg     <= rem_next;
        live_reg    <= live_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        probes_reg  <= probes_next;
        m_data_reg  <= m_data_next;
    end

endmodule

@@ rtl/cht_checker.sv @@
// Port-level checker for the chained hash table unit, bound to the top level.
// Depends on cht_pkg and chained_hash_table_unit.
module cht_checker
    import cht_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input cht_out_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // one transaction in flight: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted transaction");

    // reset empties the output and starts the head sweep
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output valid or input ready right after reset");

    a_miss_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_MISS) |-> (m_data.found_key == '0))
        else $error("search miss reports a key");

    a_full_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL) |->
            (m_data.found_key == '0) && (m_data.probe_count == '0))
        else $error("refused insert carries data");

endmodule

bind chained_hash_table_unit cht_checker u_cht_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ sim/testbench.sv @@
// Self-checking testbench for chained_hash_table_unit: a directed table, then random phases.
// Depends on cht_pkg and the unit RTL; a behavioral hash table predicts every result not typed in a row.
module testbench
    import cht_pkg::*;
();

    localparam int CLK_HALF      = 4;
    localparam int NUM_BUCKETS   = DEF_BUCKETS;
    localparam int NUM_NODES     = DEF_POOL_NODES;
    // whole-run time limit, with margin over every search being a 256-node walk
    localparam int RUN_LIMIT     = 40_000_000;
    localparam int DRAIN_CYCLES  = 600;     // the longest search walks all 256 pool nodes
    localparam int LONG_HOLD     = 2500;
    localparam int NO_MOD_WRITE  = -1;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 145;
    localparam int HOLD_PHASE    = 1;
    localparam int FILL_PHASE    = 4;
    localparam int FILL_INSERTS  = 280;     // enough to overflow the pool
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    cht_in_t          s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    cht_out_t         m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [MOD_W-1:0] cfg_wr_data = '0;

    always #(CLK_HALF) aclk = ~aclk;

    chained_hash_table_unit #(
        .BUCKETS    (NUM_BUCKETS),
        .POOL_NODES (NUM_NODES)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Behavioral hash table: bucket heads, node pool, modulus register
    // ------------------------------------------------------------------
    logic [MOD_W-1:0] mdl_modulus;
    int unsigned      bkt_first     [NUM_BUCKETS];
    bit               bkt_live      [NUM_BUCKETS];
    logic [KEY_W-1:0] pool_key      [NUM_NODES];
    int unsigned      pool_next     [NUM_NODES];
    bit               pool_has_next [NUM_NODES];
    int unsigned      pool_used;

    cht_out_t         awaited_results [$];  // oldest first
    logic [KEY_W-1:0] stored_keys     [$];  // keys live in the table, for search hits

    // stimulus mode, shared with the result sink
    bit tx_no_gaps   = 1'b0;
    bit rx_no_stalls = 1'b0;
    bit rx_hold_req  = 1'b0;

    int fail_count  = 0;
    int items_sent  = 0;
    int mod_writes  = 0;
    int hits        = 0;
    int misses      = 0;
    int refused     = 0;
    int clears      = 0;

    function automatic void empty_buckets();
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            bkt_live[i]  = 1'b0;
            bkt_first[i] = 0;
        end
        pool_used = 0;
    endfunction

    // division hash, with the modulus clamped into 2..BUCKETS
    function automatic int unsigned bucket_of_key(input logic [KEY_W-1:0] key);
        int unsigned m;
        int unsigned k;
        m = mdl_modulus;
        k = key;
        if (m < MOD_MIN) m = MOD_MIN;
        if (m > NUM_BUCKETS) m = NUM_BUCKETS;
        return k % m;
    endfunction

    // Applies one transaction to the table and returns the result it must produce.
    function automatic cht_out_t table_step(input cht_in_t item);
        cht_out_t    res;
        int unsigned b;
        int unsigned cur;
        int unsigned steps;
        bit          more;
        res = '0;
        case (item.op)
            OP_INSERT: begin
                if (pool_used >= NUM_NODES) begin
                    res.status = ST_FULL;
                end else begin
                    b = bucket_of_key(item.key);
                    pool_key[pool_used]      = item.key;
                    pool_has_next[pool_used] = bkt_live[b];
                    pool_next[pool_used]     = bkt_first[b];
                    bkt_first[b]             = pool_used;
                    bkt_live[b]              = 1'b1;
                    pool_used++;
                end
            end
            OP_SEARCH: begin
                b          = bucket_of_key(item.key);
                more       = bkt_live[b];
                cur        = bkt_first[b];
                steps      = 0;
                res.status = ST_MISS;
                // newest node first; stop at the first match
                while (res.status == ST_MISS && more && cur < NUM_NODES && steps < pool_used) begin
                    steps++;
                    if (pool_key[cur] == item.key) begin
                        res.status    = ST_OK;
                        res.found_key = item.key;
                    end else begin
                        more = pool_has_next[cur];
                        cur  = pool_next[cur];
                    end
                end
                res.probe_count = PROBE_W'(steps);
            end
            OP_CLEAR: begin
                empty_buckets();
            end
            default: ;
        endcase
        return res;
    endfunction

    // Random key: live keys for hits, colliding multiples, extremes, full-width noise.
    function automatic cht_in_t make_item(input logic [OP_W-1:0] op);
        cht_in_t     it;
        int unsigned sel;
        sel   = $urandom_range(0, 9);
        it.op = op;
        if (sel < 3 && stored_keys.size() > 0)
            it.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (sel < 5)
            it.key = KEY_W'($urandom);
        else if (sel < 7)
            it.key = KEY_W'($urandom_range(0, 1023));
        else if (sel == 7)
            it.key = KEY_W'($urandom_range(0, 65535) << 8);
        else if (sel == 8)
            it.key = KEY_MAX - KEY_W'($urandom_range(0, 3));
        else
            it.key = KEY_W'($urandom_range(0, 3));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offers one transaction, waits for the handshake, then records what is due.
    // A typed row overrides the predicted result but still updates the table.
    task automatic offer(input cht_in_t item, input bit typed, input cht_out_t want);
        int       gap;
        cht_out_t predicted;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = table_step(item);
        if (item.op == OP_INSERT && predicted.status == ST_OK) stored_keys.push_back(item.key);
        if (item.op == OP_CLEAR) begin
            stored_keys.delete();
            clears++;
        end
        if (item.op == OP_SEARCH && predicted.status == ST_OK) hits++;
        if (item.op == OP_SEARCH && predicted.status == ST_MISS) misses++;
        if (predicted.status == ST_FULL) refused++;
        awaited_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Every transaction yields a result, so an empty queue means the unit is idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_modulus(input logic [MOD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        mdl_modulus  = value;
        mod_writes++;
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        int       new_mod;   // NO_MOD_WRITE leaves the modulus alone
        cht_in_t  item;
        bit       typed;     // want holds the result; otherwise predicted
        cht_out_t want;
    } plan_row_t;

    plan_row_t directed_plan [$];

    task automatic add_row(input int new_mod, input logic [OP_W-1:0] op,
                           input logic [KEY_W-1:0] key, input bit typed,
                           input logic [STATUS_W-1:0] st, input logic [PROBE_W-1:0] probes);
        plan_row_t row;
        row.new_mod          = new_mod;
        row.item.op          = op;
        row.item.key         = key;
        row.typed            = typed;
        row.want.status      = st;
        row.want.found_key   = '0;
        row.want.probe_count = probes;
        directed_plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold on request, field checks
    // ------------------------------------------------------------------
    initial begin : result_sink
        int       stall;
        cht_out_t want;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 9);
            if (rx_hold_req) begin
                // hold off so the output register and the sequencer both fill
                rx_hold_req = 1'b0;
                stall       = LONG_HOLD;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d found_key %h probe_count %0d",
                         $time, m_data.status, m_data.found_key, m_data.probe_count);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.found_key !== want.found_key) begin
                    $display("%0t: found_key expected %h actual %h",
                             $time, want.found_key, m_data.found_key);
                    fail_count++;
                end
                if (m_data.probe_count !== want.probe_count) begin
                    $display("%0t: probe_count expected %0d actual %0d",
                             $time, want.probe_count, m_data.probe_count);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int               n;
        int               ins_pct;
        int unsigned      r;
        logic [OP_W-1:0]  op;
        logic [MOD_W-1:0] mod_val;
        logic [MOD_W-1:0] fixed_mods [6];

        fixed_mods = '{MOD_W'(2), MOD_W'(256), MOD_W'(0), MOD_W'(511), MOD_W'(1), MOD_W'(257)};

        mdl_modulus = MOD_RESET;
        empty_buckets();

        // modulus 0 acts as 2: small chains in buckets 0 and 1
        add_row(0,            OP_SEARCH, 31'd5,    1'b1, ST_MISS, '0);  // empty table
        add_row(NO_MOD_WRITE, OP_INSERT, 31'd0,    1'b1, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_INSERT, KEY_MAX,  1'b1, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_INSERT, 31'd2,    1'b1, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'd0,    1'b0, ST_OK,   '0);  // hit on key zero
        add_row(NO_MOD_WRITE, OP_SEARCH, KEY_MAX,  1'b0, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_INSERT, 31'd2,    1'b1, ST_OK,   '0);  // duplicate
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'd2,    1'b0, ST_OK,   '0);  // newest copy first
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'd4,    1'b0, ST_OK,   '0);  // miss, full walk
        add_row(NO_MOD_WRITE, OP_NOP,    KEY_MAX,  1'b1, ST_OK,   '0);
        // above BUCKETS acts as BUCKETS; old keys stay where they went
        add_row(511,          OP_SEARCH, 31'd2,    1'b0, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'd0,    1'b0, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_INSERT, 31'd300,  1'b1, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'd300,  1'b0, ST_OK,   '0);
        add_row(1,            OP_SEARCH, 31'd300,  1'b0, ST_OK,   '0);  // now hashes to 0
        add_row(NO_MOD_WRITE, OP_CLEAR,  31'h5555_5555, 1'b1, ST_OK, '0);
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'd0,    1'b1, ST_MISS, '0);
        add_row(256,          OP_INSERT, 31'd256,  1'b1, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'h2AAA_AAAA, 1'b0, ST_OK, '0);
        add_row(257,          OP_INSERT, 31'h7FFF_FF00, 1'b1, ST_OK, '0);
        add_row(NO_MOD_WRITE, OP_SEARCH, 31'h7FFF_FF00, 1'b0, ST_OK, '0);
        add_row(NO_MOD_WRITE, OP_NOP,    31'd0,    1'b1, ST_OK,   '0);
        add_row(NO_MOD_WRITE, OP_CLEAR,  KEY_MAX,  1'b1, ST_OK,   '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // the unit sweeps its bucket heads after reset; offer() just waits on s_ready
        foreach (directed_plan[i]) begin
            if (directed_plan[i].new_mod != NO_MOD_WRITE) begin
                drain();
                set_modulus(MOD_W'(directed_plan[i].new_mod));
            end
            offer(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p < 6)
                mod_val = fixed_mods[p];
            else if (p == PHASES - 1)
                mod_val = MOD_W'($urandom_range(0, 511));
            else
                mod_val = MOD_W'($urandom_range(2, 256));
            set_modulus(mod_val);

            tx_no_gaps   = ($urandom_range(0, 3) == 0);
            rx_no_stalls = ($urandom_range(0, 3) == 0);
            if (p == HOLD_PHASE) begin
                tx_no_gaps  = 1'b1;
                rx_hold_req = 1'b1;
            end

            if (p == FILL_PHASE) begin
                // fresh pool, overfill it, searches mixed in
                offer(make_item(OP_CLEAR), 1'b0, '0);
                n = 0;
                while (n < FILL_INSERTS) begin
                    if ($urandom_range(0, 4) != 0) begin
                        op = OP_INSERT;
                        n++;
                    end else begin
                        op = OP_SEARCH;
                    end
                    offer(make_item(op), 1'b0, '0);
                end
            end else begin
                ins_pct = $urandom_range(30, 70);
                repeat (PHASE_ITEMS) begin
                    r = $urandom_range(0, 99);
                    if (r < ins_pct)  op = OP_INSERT;
                    else if (r < 97)  op = OP_SEARCH;
                    else if (r < 99)  op = OP_NOP;
                    else              op = OP_CLEAR;
                    offer(make_item(op), 1'b0, '0);
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Coverage: %0d transactions over %0d modulus settings (0, 1, 2, 256, 257, 511).",
                 items_sent, mod_writes);
        $display("Search hits %0d, misses %0d; inserts refused on full pool %0d; clears %0d.",
                 hits, misses, refused, clears);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
